// ===== src/chacha20_stream_xor_macros.svh =====
`ifndef CHACHA20_STREAM_XOR_MACROS_SVH
`define CHACHA20_STREAM_XOR_MACROS_SVH

// Check that cons holds in the cycle after ante.
`define CC20_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check that cons holds in the same cycle as ante.
`define CC20_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/cc20_pkg.sv =====
`default_nettype none

package cc20_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int WORD_W = 32;
  localparam int BLOCK_W = 512;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_CNT = 3'd6;

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/chacha20_stream_xor.sv =====
// One byte is in work at a time: it is taken in S_IDLE and XORed in S_XOR, and a stalled
// result holds it there. A new block (first byte, after 64 bytes, after a last byte or after
// a REG_START_CNT write) first runs the shared half-quarter-round unit in S_GEN.
// Reset (rst, synchronous): key, nonce and block counter go to zero, no block is held,
// both channels go idle.
`default_nettype none

module chacha20_stream_xor
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 data_valid,
  output logic                 data_stall,
  input  in_item_t             data_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output out_item_t            result_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_GEN, S_XOR} state_t;

  state_t             state;
  logic [CFG_W-1:0]   key0;
  logic [CFG_W-1:0]   key1;
  logic [CFG_W-1:0]   key2;
  logic [CFG_W-1:0]   key3;
  logic [CFG_W-1:0]   nonce_lo;
  logic [WORD_W-1:0]  nonce_hi;
  logic [WORD_W-1:0]  counter;
  logic [5:0]         pos;
  logic               block_valid;
  in_item_t           held;
  logic [BLOCK_W-1:0] init;
  logic [BLOCK_W-1:0] block;
  logic               core_start;
  logic               core_done;
  logic [7:0]         ks_byte;
  logic               beat_in;

  assign init = {nonce_hi, nonce_lo[63:32], nonce_lo[31:0], counter,
                 key3[63:32], key3[31:0], key2[63:32], key2[31:0],
                 key1[63:32], key1[31:0], key0[63:32], key0[31:0],
                 SIGMA3, SIGMA2, SIGMA1, SIGMA0};

  assign data_stall = (state != S_IDLE);
  assign beat_in    = data_valid && !data_stall;
  assign core_start = beat_in && !block_valid;
  assign ks_byte    = block[{pos, 3'b000} +: 8];

  cc20_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .start (core_start),
    .init  (init),
    .done  (core_done),
    .block (block)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      key0         <= '0;
      key1         <= '0;
      key2         <= '0;
      key3         <= '0;
      nonce_lo     <= '0;
      nonce_hi     <= '0;
      counter      <= '0;
      pos          <= '0;
      block_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_XOR) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (beat_in) begin
            held  <= data_item;
            state <= block_valid ? S_XOR : S_GEN;
          end
        end
        S_GEN: begin
          if (core_done) begin
            block_valid <= 1'b1;
            pos         <= '0;
            state       <= S_XOR;
          end
        end
        S_XOR: begin
          if (!result_valid || !result_stall) begin
            result_item.data_out <= held.data_in ^ ks_byte;
            result_item.last_out <= held.last_of_message;
            result_valid         <= 1'b1;
            if (pos == 6'd63 || held.last_of_message) begin
              counter     <= counter + 32'd1;
              pos         <= '0;
              block_valid <= 1'b0;
            end else begin
              pos <= pos + 6'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY0:     key0 <= cfg_data;
          REG_KEY1:     key1 <= cfg_data;
          REG_KEY2:     key2 <= cfg_data;
          REG_KEY3:     key3 <= cfg_data;
          REG_NONCE_LO: nonce_lo <= cfg_data;
          REG_NONCE_HI: nonce_hi <= cfg_data[WORD_W-1:0];
          REG_START_CNT: begin
            counter     <= cfg_data[WORD_W-1:0];
            pos         <= '0;
            block_valid <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/cc20_qr_half.sv =====
`default_nettype none

module cc20_qr_half
  import cc20_pkg::*;
(
  input  logic              phase,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  input  logic [WORD_W-1:0] c,
  input  logic [WORD_W-1:0] d,
  output logic [WORD_W-1:0] a_next,
  output logic [WORD_W-1:0] b_next,
  output logic [WORD_W-1:0] c_next,
  output logic [WORD_W-1:0] d_next
);

  logic [WORD_W-1:0] dx;
  logic [WORD_W-1:0] bx;

  always_comb begin
    a_next = a + b;
    dx = d ^ a_next;
    if (!phase) begin
      d_next = {dx[15:0], dx[31:16]};
    end else begin
      d_next = {dx[23:0], dx[31:24]};
    end
    c_next = c + d_next;
    bx = b ^ c_next;
    if (!phase) begin
      b_next = {bx[19:0], bx[31:20]};
    end else begin
      b_next = {bx[24:0], bx[31:25]};
    end
  end

endmodule

`default_nettype wire

// ===== src/cc20_core.sv =====
`default_nettype none

module cc20_core
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [BLOCK_W-1:0] init,
  output logic               done,
  output logic [BLOCK_W-1:0] block
);

  localparam int DrW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [3:0] StepColEnd = 4'd7;
  localparam logic [3:0] StepLast = 4'd15;

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} cstate_t;

  cstate_t           state;
  logic [3:0]        step;
  logic [DrW-1:0]    dr;
  logic [WORD_W-1:0] w [16];
  logic [WORD_W-1:0] half [16];
  logic [WORD_W-1:0] shifted [16];
  logic [WORD_W-1:0] diag [16];
  logic [WORD_W-1:0] undiag [16];
  logic [WORD_W-1:0] w_next [16];
  logic [WORD_W-1:0] qa;
  logic [WORD_W-1:0] qb;
  logic [WORD_W-1:0] qc;
  logic [WORD_W-1:0] qd;

  cc20_qr_half u_qr (
    .phase  (step[0]),
    .a      (w[0]),
    .b      (w[4]),
    .c      (w[8]),
    .d      (w[12]),
    .a_next (qa),
    .b_next (qb),
    .c_next (qc),
    .d_next (qd)
  );

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      half[i] = w[i];
    end
    half[0]  = qa;
    half[4]  = qb;
    half[8]  = qc;
    half[12] = qd;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        shifted[r*4+c] = half[r*4+((c+1)%4)];
      end
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        diag[r*4+c]   = shifted[r*4+((c+r)%4)];
        undiag[r*4+c] = shifted[r*4+((c+4-r)%4)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (!step[0]) begin
        w_next[i] = half[i];
      end else if (step == StepColEnd) begin
        w_next[i] = diag[i];
      end else if (step == StepLast) begin
        w_next[i] = undiag[i];
      end else begin
        w_next[i] = shifted[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      block[WORD_W*i +: WORD_W] = w[i];
    end
  end

  assign done = (state == C_FINAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      step  <= '0;
      dr    <= '0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            for (int i = 0; i < 16; i++) begin
              w[i] <= init[WORD_W*i +: WORD_W];
            end
            step  <= '0;
            dr    <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          for (int i = 0; i < 16; i++) begin
            w[i] <= w_next[i];
          end
          step <= step + 4'd1;
          if (step == StepLast) begin
            if (dr == DrW'(DOUBLE_ROUNDS - 1)) begin
              state <= C_FINAL;
            end else begin
              dr <= dr + DrW'(1);
            end
          end
        end
        C_FINAL: begin
          for (int i = 0; i < 16; i++) begin
            w[i] <= w[i] + init[WORD_W*i +: WORD_W];
          end
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/cc20_checker.sv =====
`default_nettype none

`include "chacha20_stream_xor_macros.svh"

module cc20_checker
  import cc20_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 data_valid,
  input logic                 data_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input out_item_t            result_item
);

  `CC20_ASSERT_NEXT(a_busy_after_beat, clk, rst, data_valid && !data_stall, data_stall, "input side open right after a beat")
  `CC20_ASSERT_SAME(a_result_from_work, clk, rst, $rose(result_valid), $past(data_stall), "result appeared with no byte in work")
  `CC20_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && result_stall, result_valid && $stable(result_item), "stalled result changed")
  `CC20_ASSERT_NEXT(a_one_result_per_beat, clk, rst, data_valid && !data_stall, !$rose(result_valid), "result appeared in the cycle after a beat")

endmodule

bind chacha20_stream_xor cc20_checker u_checker (.*);

`default_nettype wire
